### rtl/pdpg_pkg.sv
// ----------------------------------------------------------------------------
// pdpg_pkg
// Shared types and constants of the percent-duty PWM timer.
// ----------------------------------------------------------------------------
package pdpg_pkg;

  localparam int CHANNEL_COUNT   = 6;
  localparam int CLOCK_FREQUENCY = 48000000;
  localparam int COUNTER_WIDTH   = 16;

  localparam int REQ_W       = 2;
  localparam int CH_W        = 3;
  localparam int IN_DUTY_W   = 8;
  localparam int PWM_W       = 6;
  localparam int DUTY_W      = 7;
  localparam int FREQ_W      = 26;
  localparam int CFG_IDX_W   = 2;

  localparam int DUTY_MAX        = 100;
  localparam int RESET_FREQUENCY = 25000;

  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PROD_W   = COUNTER_WIDTH + DUTY_W;
  localparam int CLK_W    = $clog2(CLOCK_FREQUENCY + 1);
  localparam int STEP_W   = $clog2(CLK_W + 1);

  localparam longint COUNTER_MAX    = (64'd1 << COUNTER_WIDTH) - 64'd1;
  localparam longint RESET_QUOTIENT = CLOCK_FREQUENCY / RESET_FREQUENCY;
  localparam logic [COUNTER_WIDTH-1:0] RESET_MODULO =
      (RESET_QUOTIENT == 0) ? '0 :
      ((RESET_QUOTIENT - 1) > COUNTER_MAX) ? '1 :
      COUNTER_WIDTH'(RESET_QUOTIENT - 1);

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_ENABLE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_APPLY
  } pdpg_state_t;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [CH_W-1:0]      channel;
    logic [IN_DUTY_W-1:0] duty_req;
  } in_item_t;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_out;
    logic              period_wrap;
    logic              status;
    logic [DUTY_W-1:0] duty_readback;
  } out_item_t;

  typedef struct packed {
    logic                     done;
    logic [COUNTER_WIDTH-1:0] modulo;
  } div_result_t;

endpackage

### rtl/pdpg_modulo_div.sv
// ----------------------------------------------------------------------------
// pdpg_modulo_div
// Restoring divider, one quotient bit per cycle: clock frequency over the
// requested frequency, turned into a saturated counter modulo.
// ----------------------------------------------------------------------------
module pdpg_modulo_div import pdpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FREQ_W-1:0] frequency,
  output div_result_t       result
);

  logic                     running;
  logic [STEP_W-1:0]        step_count;
  logic [FREQ_W-1:0]        divisor;
  logic [FREQ_W-1:0]        remainder;
  logic [CLK_W-1:0]         quotient;

  logic [FREQ_W:0]          trial;
  logic                     fits;
  logic [FREQ_W-1:0]        remainder_next;
  logic [CLK_W-1:0]         quotient_next;
  logic [CLK_W-1:0]         quotient_less;
  logic [COUNTER_WIDTH-1:0] modulo_calc;

  always_comb begin
    trial          = {remainder, quotient[CLK_W-1]};
    fits           = trial >= {1'b0, divisor};
    remainder_next = fits ? FREQ_W'(trial - {1'b0, divisor}) : trial[FREQ_W-1:0];
    quotient_next  = {quotient[CLK_W-2:0], fits};
    quotient_less  = quotient_next - 1'b1;
    if (quotient_next == '0) begin
      modulo_calc = '0;
    end else if (64'(quotient_less) > COUNTER_MAX) begin
      modulo_calc = '1;
    end else begin
      modulo_calc = COUNTER_WIDTH'(quotient_less);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      result.done <= 1'b0;
    end else begin
      result.done <= running && !start && (step_count == STEP_W'(1));
      if (start) begin
        running    <= 1'b1;
        step_count <= STEP_W'(CLK_W);
        divisor    <= frequency;
        remainder  <= '0;
        quotient   <= CLK_W'(CLOCK_FREQUENCY);
      end else if (running) begin
        remainder  <= remainder_next;
        quotient   <= quotient_next;
        step_count <= step_count - 1'b1;
        if (step_count == STEP_W'(1)) begin
          running       <= 1'b0;
          result.modulo <= modulo_calc;
        end
      end
    end
  end

endmodule

### rtl/percent_duty_pwm_generator.sv
// ----------------------------------------------------------------------------
// percent_duty_pwm_generator
// Six-channel edge-aligned PWM timer with duty set in percent.
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid/item_ready, item): ticks, duty writes and duty
//   reads; every transaction gives exactly one result transaction on
//   result_valid/result_ready, result, in order.
//   an accepted item passes the single input register, then the result register;
//   one item per cycle while results are taken and no recompute is running.
//   configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
//   frequency in hertz, index 1 the counter enable. a nonzero frequency write
//   runs a 26-step bit-serial divider, whose registered done flag hands over
//   its result, then the apply state loads every channel's duty product;
//   cfg_ready and item_ready stay low meanwhile.
//   reset: counter 0, modulo 1919 (25 kHz), all duties 0, counter stopped.
//   a stalled receiver holds the result; one more item is taken into the
//   input register, after which item_ready drops until the result moves.
// ----------------------------------------------------------------------------
module percent_duty_pwm_generator import pdpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data
);

  pdpg_state_t              state, state_next;
  div_result_t              div_result;
  logic                     div_start;
  logic                     cfg_write;

  logic                     counter_enable;
  logic [COUNTER_WIDTH-1:0] period_counter;
  logic [COUNTER_WIDTH-1:0] modulo_value;
  logic [DUTY_W-1:0]        duty_store [CHANNEL_COUNT];
  logic [PROD_W-1:0]        products   [CHANNEL_COUNT];
  logic [PROD_W-1:0]        apply_product [CHANNEL_COUNT];

  logic                     hold_valid;
  in_item_t                 hold_item;
  logic                     advance;

  logic                     channel_ok;
  logic [CH_IDX_W-1:0]      channel_idx;
  logic [DUTY_W-1:0]        duty_clamped;
  logic [PROD_W-1:0]        write_product;
  logic [COUNTER_WIDTH-1:0] period_counter_next;
  logic [DUTY_W-1:0]        duty_store_next [CHANNEL_COUNT];
  logic [PROD_W-1:0]        products_next   [CHANNEL_COUNT];
  logic [PROD_W-1:0]        scaled_count;
  logic [CHANNEL_COUNT-1:0] pwm_bits;
  out_item_t                result_next;

  assign cfg_ready  = (state == ST_IDLE);
  assign cfg_write  = cfg_valid && cfg_ready;
  assign div_start  = cfg_write && (cfg_index == REG_FREQUENCY) && (cfg_data != '0);
  assign advance    = hold_valid && (state == ST_IDLE) && (!result_valid || result_ready);
  assign item_ready = (state == ST_IDLE) && (!hold_valid || advance);

  pdpg_modulo_div u_modulo_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .frequency (cfg_data),
    .result    (div_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (div_start) state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_result.done) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      apply_product[c] = PROD_W'(modulo_value) * PROD_W'(duty_store[c]);
    end
  end

  // compare value is floor(modulo * duty / 100), so counter < compare
  // is the same as 100 * (counter + 1) <= modulo * duty
  always_comb begin
    channel_ok    = hold_item.channel < CH_W'(CHANNEL_COUNT);
    channel_idx   = hold_item.channel[CH_IDX_W-1:0];
    duty_clamped  = (hold_item.duty_req > IN_DUTY_W'(DUTY_MAX)) ?
                    DUTY_W'(DUTY_MAX) : hold_item.duty_req[DUTY_W-1:0];
    write_product = PROD_W'(modulo_value) * PROD_W'(duty_clamped);

    period_counter_next = period_counter;
    duty_store_next     = duty_store;
    products_next       = products;
    result_next         = '0;

    case (hold_item.req_type)
      REQ_TICK: begin
        if (counter_enable) begin
          if (period_counter >= modulo_value) begin
            period_counter_next     = '0;
            result_next.period_wrap = 1'b1;
          end else begin
            period_counter_next = period_counter + 1'b1;
          end
        end
      end
      REQ_WRITE: begin
        if (!channel_ok) begin
          result_next.status = 1'b1;
        end else begin
          duty_store_next[channel_idx] = duty_clamped;
          products_next[channel_idx]   = write_product;
        end
      end
      REQ_READ: begin
        if (channel_ok) result_next.duty_readback = duty_store[channel_idx];
      end
      default: ;
    endcase

    scaled_count = (PROD_W'(period_counter_next) + 1'b1) * PROD_W'(DUTY_MAX);
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      pwm_bits[c] = scaled_count <= products_next[c];
    end
    result_next.pwm_out = PWM_W'(pwm_bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_enable <= 1'b0;
      period_counter <= '0;
      modulo_value   <= RESET_MODULO;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        duty_store[c] <= '0;
        products[c]   <= '0;
      end
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == REG_COUNTER_ENABLE)) begin
        counter_enable <= cfg_data[0];
      end
      if (state == ST_DIVIDE && div_result.done) begin
        modulo_value <= div_result.modulo;
      end
      if (state == ST_APPLY) begin
        period_counter <= '0;
        products       <= apply_product;
      end

      if (item_valid && item_ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end

      if (advance) begin
        period_counter <= period_counter_next;
        duty_store     <= duty_store_next;
        products       <= products_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) hold_item <= item;
    if (advance) result <= result_next;
  end

endmodule

### rtl/pdpg_checker.sv
// ----------------------------------------------------------------------------
// pdpg_checker
// Port-level checks of the percent-duty PWM timer, bound to the top level.
// ----------------------------------------------------------------------------
module pdpg_checker import pdpg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input in_item_t             item,
  input logic                 result_valid,
  input logic                 result_ready,
  input out_item_t            result,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [FREQ_W-1:0]    cfg_data
);

  // no items while the period is recomputed
  a_busy_blocks_items: assert property (@(posedge clk) disable iff (rst)
    !cfg_ready |-> !item_ready)
    else $error("item taken during recompute");

  a_frequency_starts_recompute: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_FREQUENCY && cfg_data != '0
    |=> !cfg_ready)
    else $error("frequency write did not start recompute");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> !result.period_wrap && result.duty_readback == '0)
    else $error("rejected write carries other flags");

  a_readback_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.duty_readback <= DUTY_W'(DUTY_MAX))
    else $error("duty readback above limit");

endmodule

bind percent_duty_pwm_generator pdpg_checker u_pdpg_checker (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the percent-duty PWM timer. Transactions are driven
// in random bursts while the result side stalls on its own pattern. Every
// result is checked field by field against its directed row's value, if any,
// else a cycle-free timer model: counter, modulo, per-channel duties and
// compare values. A directed table covers clamping, bad channels, the spare
// request code, zero and out-of-range frequencies, saturation and the counter
// enable. Random phases under several frequency and enable settings follow.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pdpg_pkg::*;

  localparam logic [REQ_W-1:0]     REQ_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PLAN_ROWS     = 33;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_BLOCKS
  } ready_mode_t;

  typedef struct {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [FREQ_W-1:0]    reg_data;
    in_item_t             req;
    logic                 typed;
    out_item_t            want;
  } step_t;

  localparam in_item_t  NO_REQ  = '0;
  localparam out_item_t UNTYPED = '0;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  in_item_t             item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  out_item_t            result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [FREQ_W-1:0]    cfg_data     = '0;

  // timer model state
  logic [COUNTER_WIDTH-1:0] count_now;
  logic [COUNTER_WIDTH-1:0] modulo_now;
  logic [COUNTER_WIDTH-1:0] compare_now [CHANNEL_COUNT];
  logic [DUTY_W-1:0]        duty_now    [CHANNEL_COUNT];
  logic                     enable_now;

  out_item_t   pending_results [$];
  out_item_t   oldest;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  ready_mode_t ready_mode     = READY_ALWAYS;
  logic [4:0]  window_pos     = '0;

  step_t plan [PLAN_ROWS] = '{
    // counter stopped, reset frequency
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b1, '{6'h00, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd0, 8'd255}, 1'b1, '{6'h01, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_READ,  3'd0, 8'd0},   1'b1, '{6'h01, 1'b0, 1'b0, 7'd100}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd7, 8'd50},  1'b1, '{6'h01, 1'b0, 1'b1, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_READ,  3'd6, 8'd255}, 1'b1, '{6'h01, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd5, 8'd0},   1'b1, '{6'h01, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_UNUSED, 3'd2, 8'd255}, 1'b1, '{6'h01, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd1, 8'd100}, 1'b1, '{6'h03, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd2, 8'd101}, 1'b1, '{6'h07, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd3, 8'd1},   1'b1, '{6'h0f, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd4, 8'd50},  1'b1, '{6'h1f, 1'b0, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_READ,  3'd2, 8'd0},   1'b1, '{6'h1f, 1'b0, 1'b0, 7'd100}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b1, '{6'h1f, 1'b0, 1'b0, 7'd0}},
    // running, modulo of one
    '{1'b1, REG_COUNTER_ENABLE, 26'd1,        NO_REQ, 1'b0, UNTYPED},
    '{1'b1, REG_FREQUENCY,      26'd24000000, NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    // zero frequency is dropped
    '{1'b1, REG_FREQUENCY,      26'd0,        NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    // frequency above the clock gives a zero modulo
    '{1'b1, REG_FREQUENCY,      26'h3ffffff,  NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b1, '{6'h00, 1'b1, 1'b0, 7'd0}},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_WRITE, 3'd0, 8'd100}, 1'b0, UNTYPED},
    '{1'b1, REG_FREQUENCY,      26'd48000000, NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    // saturated modulo
    '{1'b1, REG_FREQUENCY,      26'd1,        NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_READ,  3'd7, 8'd255}, 1'b0, UNTYPED},
    // spare indexes, then stop with a wide data word
    '{1'b1, REG_SPARE_B,        26'h3ffffff,  NO_REQ, 1'b0, UNTYPED},
    '{1'b1, REG_SPARE_A,        26'd0,        NO_REQ, 1'b0, UNTYPED},
    '{1'b1, REG_COUNTER_ENABLE, 26'h3fffffe,  NO_REQ, 1'b0, UNTYPED},
    '{1'b0, REG_FREQUENCY, '0, '{REQ_TICK,  3'd0, 8'd0},   1'b0, UNTYPED},
    '{1'b1, REG_COUNTER_ENABLE, 26'd1,        NO_REQ, 1'b0, UNTYPED}
  };

  percent_duty_pwm_generator dut (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [COUNTER_WIDTH-1:0] compare_for(logic [DUTY_W-1:0] duty);
    return COUNTER_WIDTH'((longint'(modulo_now) * longint'(duty)) / DUTY_MAX);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] index,
                                         logic [FREQ_W-1:0] data);
    longint quotient;
    if (index == REG_FREQUENCY) begin
      if (data != '0) begin
        quotient = longint'(CLOCK_FREQUENCY) / longint'(data);
        quotient = (quotient == 0) ? 0 : quotient - 1;
        if (quotient > COUNTER_MAX) quotient = COUNTER_MAX;
        modulo_now = COUNTER_WIDTH'(quotient);
        for (int c = 0; c < CHANNEL_COUNT; c++) compare_now[c] = compare_for(duty_now[c]);
        count_now = '0;
      end
    end else if (index == REG_COUNTER_ENABLE) begin
      enable_now = data[0];
    end
  endfunction

  function automatic void reset_timer();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      duty_now[c]    = '0;
      compare_now[c] = '0;
    end
    enable_now = 1'b0;
    count_now  = '0;
    modulo_now = '0;
    apply_register(REG_FREQUENCY, FREQ_W'(RESET_FREQUENCY));
  endfunction

  function automatic out_item_t step_timer(in_item_t req);
    out_item_t         res;
    logic [DUTY_W-1:0] duty;
    logic              known;
    res   = '0;
    known = req.channel < CHANNEL_COUNT;
    duty  = (req.duty_req > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(req.duty_req);
    case (req.req_type)
      REQ_TICK: begin
        if (enable_now) begin
          if (count_now >= modulo_now) begin
            count_now       = '0;
            res.period_wrap = 1'b1;
          end else begin
            count_now = count_now + 1'b1;
          end
        end
      end
      REQ_WRITE: begin
        if (!known) begin
          res.status = 1'b1;
        end else begin
          duty_now[req.channel]    = duty;
          compare_now[req.channel] = compare_for(duty);
        end
      end
      REQ_READ: begin
        if (known) res.duty_readback = duty_now[req.channel];
      end
      default: ;
    endcase
    for (int c = 0; c < CHANNEL_COUNT; c++) res.pwm_out[c] = count_now < compare_now[c];
    return res;
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) req.req_type = REQ_TICK;
    else if (pick < 75) req.req_type = REQ_WRITE;
    else if (pick < 93) req.req_type = REQ_READ;
    else req.req_type = REQ_UNUSED;
    req.channel = CH_W'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) req.duty_req = IN_DUTY_W'($urandom_range(0, 255));
    else req.duty_req = IN_DUTY_W'($urandom_range(0, DUTY_MAX));
    return req;
  endfunction

  task automatic send_item(in_item_t req, logic typed, out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    oldest = step_timer(req);
    pending_results.push_back(typed ? want : oldest);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [FREQ_W-1:0] data);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(index, data);
    cfg_valid <= 1'b0;
  endtask

  // result side stall pattern, re-chosen whenever the 5-bit window counter wraps
  always @(posedge clk) begin
    window_pos <= window_pos + 1'b1;
    if (window_pos == '0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS: result_ready <= 1'b1;
      READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:      result_ready <= window_pos[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: %h", result);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (result.pwm_out !== oldest.pwm_out) begin
          $error("pwm_out: expected %h, got %h", oldest.pwm_out, result.pwm_out);
          mismatch_count++;
        end
        if (result.period_wrap !== oldest.period_wrap) begin
          $error("period_wrap: expected %b, got %b", oldest.period_wrap, result.period_wrap);
          mismatch_count++;
        end
        if (result.status !== oldest.status) begin
          $error("status: expected %b, got %b", oldest.status, result.status);
          mismatch_count++;
        end
        if (result.duty_readback !== oldest.duty_readback) begin
          $error("duty_readback: expected %0d, got %0d", oldest.duty_readback,
                 result.duty_readback);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    reset_timer();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_index, plan[i].reg_data);
      else send_item(plan[i].req, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_FREQUENCY, 26'd4800000);
          write_reg(REG_COUNTER_ENABLE, 26'd1);
        end
        1: write_reg(REG_FREQUENCY, FREQ_W'($urandom_range(480000, CLOCK_FREQUENCY)));
        2: write_reg(REG_FREQUENCY, FREQ_W'($urandom));
        3: begin
          write_reg(REG_COUNTER_ENABLE, 26'd0);
          write_reg(REG_FREQUENCY, FREQ_W'($urandom_range(1, 2000)));
        end
        4: begin
          write_reg(REG_FREQUENCY, 26'd1);
          write_reg(REG_COUNTER_ENABLE, 26'd1);
        end
        default: begin
          write_reg(REG_FREQUENCY, 26'd0);
          write_reg(REG_SPARE_A, FREQ_W'($urandom));
          write_reg(REG_FREQUENCY, FREQ_W'($urandom_range(2400000, CLOCK_FREQUENCY)));
        end
      endcase
      repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, UNTYPED);
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pdpg_pkg.sv
rtl/pdpg_modulo_div.sv
rtl/percent_duty_pwm_generator.sv
rtl/pdpg_checker.sv
verif/testbench.sv
